FILE: sv/sme_pkg.sv
// shared types and codes of the stack machine executor
package sme_pkg;

    typedef enum logic [4:0] {
        OP_HLT = 5'd0, OP_PUSH = 5'd1, OP_PUSHREG = 5'd2, OP_PUSHMEM = 5'd3,
        OP_POPREG = 5'd4, OP_POPMEM = 5'd5, OP_ADD = 5'd6, OP_SUB = 5'd7,
        OP_MUL = 5'd8, OP_DIV = 5'd9, OP_SQRT = 5'd10, OP_JB = 5'd11,
        OP_JBE = 5'd12, OP_JA = 5'd13, OP_JAE = 5'd14, OP_JE = 5'd15,
        OP_JNE = 5'd16, OP_JMP = 5'd17, OP_CALL = 5'd18, OP_RET = 5'd19,
        OP_IN = 5'd20, OP_OUT = 5'd21
    } t_op;

    localparam logic [3:0] F_NONE = 4'd0;
    localparam logic [3:0] F_UNDER = 4'd1;
    localparam logic [3:0] F_OVER = 4'd2;
    localparam logic [3:0] F_DIVZ = 4'd3;
    localparam logic [3:0] F_NSQRT = 4'd4;
    localparam logic [3:0] F_RUNDER = 4'd5;
    localparam logic [3:0] F_ROVER = 4'd6;
    localparam logic [3:0] F_BADREG = 4'd7;
    localparam logic [3:0] F_BADADDR = 4'd8;
    localparam logic [3:0] F_BADOP = 4'd9;

    // iterative unit operation select
    typedef enum logic [1:0] {
        IU_MUL = 2'd0, IU_DIV = 2'd1, IU_SQRT = 2'd2
    } t_iu_op;

    typedef struct packed {
        logic   start;
        t_iu_op op;
    } t_iu_ctl;

endpackage

FILE: sv/sme_iter.sv
// shared iterative unit: shift-add multiply, restoring divide, bitwise square root
module sme_iter
    import sme_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_iu_ctl     i_ctl,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [31:0] o_res
);

    logic        r_busy;
    logic [5:0]  r_cnt;
    t_iu_op      r_op;
    logic [31:0] r_acc;
    logic [31:0] r_x;
    logic [31:0] r_y;
    logic [32:0] r_rem;
    logic        r_neg;

    // one step of each algorithm
    logic [32:0] w_trial;
    logic [31:0] w_sq_t;
    logic [32:0] w_rshift;
    always_comb begin
        w_rshift = {r_rem[31:0], r_x[31]};
        w_trial  = w_rshift - {1'b0, r_y};
        w_sq_t   = r_acc | r_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_op   <= i_ctl.op;
                r_cnt  <= 6'd0;
                r_acc  <= '0;
                r_rem  <= '0;
                case (i_ctl.op)
                    IU_MUL: begin
                        r_x <= i_a;
                        r_y <= i_b;
                    end
                    IU_DIV: begin
                        r_x   <= i_a[31] ? 32'd0 - i_a : i_a;
                        r_y   <= i_b[31] ? 32'd0 - i_b : i_b;
                        r_neg <= i_a[31] ^ i_b[31];
                    end
                    default: begin
                        r_x <= i_a;
                        r_y <= 32'h4000_0000;
                    end
                endcase
            end else if (r_busy) begin
                case (r_op)
                    IU_MUL: begin
                        if (r_y[0]) r_acc <= r_acc + r_x;
                        r_x <= {r_x[30:0], 1'b0};
                        r_y <= {1'b0, r_y[31:1]};
                    end
                    IU_DIV: begin
                        if (!w_trial[32]) begin
                            r_rem <= w_trial;
                            r_acc <= {r_acc[30:0], 1'b1};
                        end else begin
                            r_rem <= w_rshift;
                            r_acc <= {r_acc[30:0], 1'b0};
                        end
                        r_x <= {r_x[30:0], 1'b0};
                    end
                    default: begin
                        if (r_x >= w_sq_t) begin
                            r_x   <= r_x - w_sq_t;
                            r_acc <= {1'b0, r_acc[31:1]} | r_y;
                        end else begin
                            r_acc <= {1'b0, r_acc[31:1]};
                        end
                        r_y <= {2'b00, r_y[31:2]};
                    end
                endcase
                r_cnt <= r_cnt + 6'd1;
                if ((r_op == IU_SQRT && r_cnt == 6'd15) || r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // final sign fix for divide; mul and sqrt in acc after last step
    logic [31:0] w_last;
    always_comb begin
        w_last = r_acc;
        o_res  = (r_op == IU_DIV && r_neg) ? 32'd0 - w_last : w_last;
    end

endmodule

FILE: sv/stack_machine_executor_core.sv
// top level of the stack machine executor
// One instruction is taken per transfer and answered by one result transfer. After reset a
// clearing pass zeroes every data memory word before the first instruction is taken. The
// single-port data stack is read for the top and second entries, and for pushmem the data
// memory, one after another, before execution; mul, div and sqrt then run in the shared
// iterative unit (sqrt 16 steps, mul and div 32 steps). A result waits in the output
// register until its transfer, and the next instruction is taken only after that.
module stack_machine_executor_core
    import sme_pkg::*;
#(
    parameter int DATA_DEPTH   = 64,
    parameter int RETURN_DEPTH = 16,
    parameter int NUM_REGS     = 8,
    parameter int RAM_WORDS    = 8192,
    parameter int PC_START     = 3
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [4:0]  i_kind,
    input  logic [31:0] i_operand,
    input  logic [7:0]  i_port_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_next_pc,
    output logic        o_out_valid,
    output logic [31:0] o_out_value,
    output logic        o_halted,
    output logic [3:0]  o_fault
);

    localparam int DW = $clog2(DATA_DEPTH);
    localparam int DC = $clog2(DATA_DEPTH + 1);
    localparam int RW = (RETURN_DEPTH > 1) ? $clog2(RETURN_DEPTH) : 1;
    localparam int RC = $clog2(RETURN_DEPTH + 1);
    localparam int GW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int AW = $clog2(RAM_WORDS);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD1, S_RD2, S_MEMRD, S_EXEC, S_ITER, S_WB, S_OUT
    } t_state;

    t_state       r_state;
    logic [31:0]  r_dstk [DATA_DEPTH];
    logic [15:0]  r_rstk [RETURN_DEPTH];
    logic [31:0]  r_ram  [RAM_WORDS];
    logic [31:0]  r_regs [NUM_REGS];
    logic [DC-1:0] r_dcnt;
    logic [RC-1:0] r_rcnt;
    logic [15:0]  r_pc;
    logic         r_stop;
    logic [3:0]   r_fault;
    logic [AW:0]  r_clr;
    t_op          r_op;
    logic [4:0]   r_kind;
    logic [31:0]  r_opd;
    logic [7:0]   r_port;
    logic [31:0]  r_a1;
    logic [31:0]  r_a2;
    logic [31:0]  r_mem_q;
    logic [31:0]  r_res;
    logic         r_valid;
    logic [15:0]  r_npc;
    logic         r_ov;
    logic [31:0]  r_oval;

    // shared iterative unit
    t_iu_ctl     w_iu;
    logic [31:0] w_iu_a;
    logic        w_iu_done;
    logic [31:0] w_iu_res;
    sme_iter u_iter (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_iu),
        .i_a    (w_iu_a),
        .i_b    (r_a2),
        .o_done (w_iu_done),
        .o_res  (w_iu_res)
    );

    // decode helpers
    logic         w_reg_ok;
    logic [31:0]  w_regv;
    logic         w_addr_ok;
    logic         w_cmp;
    logic [15:0]  w_pc1;
    logic [15:0]  w_pc2;
    always_comb begin
        w_reg_ok  = r_opd < 32'(NUM_REGS);
        w_regv    = r_regs[r_opd[GW-1:0]];
        w_addr_ok = w_regv < 32'(RAM_WORDS);
        w_pc1     = r_pc + 16'd1;
        w_pc2     = r_pc + 16'd2;
        case (r_op)
            OP_JB:   w_cmp = $signed(r_a1) <  $signed(r_a2);
            OP_JBE:  w_cmp = $signed(r_a1) <= $signed(r_a2);
            OP_JA:   w_cmp = $signed(r_a1) >  $signed(r_a2);
            OP_JAE:  w_cmp = $signed(r_a1) >= $signed(r_a2);
            OP_JE:   w_cmp = r_a1 == r_a2;
            default: w_cmp = r_a1 != r_a2;
        endcase
    end

    assign o_ready     = (r_state == S_IDLE) && !r_valid;
    assign o_valid     = r_valid;
    assign o_next_pc   = r_npc;
    assign o_out_valid = r_ov;
    assign o_out_value = r_oval;
    assign o_halted    = r_stop;
    assign o_fault     = r_fault;

    // start the unit exactly when the sequencer moves to the iterative state
    always_comb begin
        w_iu_a     = (r_op == OP_SQRT) ? r_a2 : r_a1;
        w_iu.start = (r_state == S_EXEC) && !r_stop && (r_fault == F_NONE) &&
                     ((((r_op == OP_MUL) || (r_op == OP_DIV && r_a2 != 32'd0)) &&
                       r_dcnt >= DC'(2)) ||
                      (r_op == OP_SQRT && r_dcnt >= DC'(1) && !r_a2[31]));
        case (r_op)
            OP_MUL:  w_iu.op = IU_MUL;
            OP_DIV:  w_iu.op = IU_DIV;
            default: w_iu.op = IU_SQRT;
        endcase
    end

    // memories: plain clocked arrays
    logic         w_ram_we;
    logic [AW-1:0] w_ram_wa;
    logic [31:0]  w_ram_wd;
    always_ff @(posedge i_clk) begin
        if (w_ram_we) r_ram[w_ram_wa] <= w_ram_wd;
        r_mem_q <= r_ram[w_regv[AW-1:0]];
    end

    always_comb begin
        w_ram_we = 1'b0;
        w_ram_wa = r_clr[AW-1:0];
        w_ram_wd = '0;
        if (r_state == S_CLEAR) begin
            w_ram_we = 1'b1;
        end else if (r_state == S_WB && r_op == OP_POPMEM) begin
            w_ram_we = 1'b1;
            w_ram_wa = w_regv[AW-1:0];
            w_ram_wd = r_a2;
        end
    end

    // sequencer with result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_dcnt  <= '0;
            r_rcnt  <= '0;
            r_pc    <= 16'(PC_START);
            r_stop  <= 1'b0;
            r_fault <= F_NONE;
            r_valid <= 1'b0;
            for (int g = 0; g < NUM_REGS; g++) r_regs[g] <= '0;
        end else begin
            if (r_valid && i_ready) r_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW + 1)'(RAM_WORDS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_kind  <= i_kind;
                        r_op    <= t_op'(i_kind);
                        r_opd   <= i_operand;
                        r_port  <= i_port_value;
                        r_state <= S_RD1;
                    end
                end
                S_RD1: begin
                    // read top of stack
                    r_a2    <= r_dstk[DW'(r_dcnt - DC'(1))];
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    // read second entry
                    r_a1    <= r_dstk[DW'(r_dcnt - DC'(2))];
                    r_state <= (r_op == OP_PUSHMEM) ? S_MEMRD : S_EXEC;
                end
                S_MEMRD: r_state <= S_EXEC;
                S_EXEC: begin
                    r_npc   <= r_pc;
                    r_ov    <= 1'b0;
                    r_oval  <= '0;
                    r_state <= S_OUT;
                    if (r_stop || r_fault != F_NONE) begin
                        r_npc <= r_pc;
                    end else if (r_kind > 5'd21) begin
                        r_fault <= F_BADOP;
                    end else begin
                        case (r_op)
                            OP_HLT: r_stop <= 1'b1;
                            OP_PUSH, OP_PUSHREG, OP_PUSHMEM, OP_IN: begin
                                if (r_dcnt >= DC'(DATA_DEPTH)) r_fault <= F_OVER;
                                else if (r_op == OP_PUSH || r_op == OP_IN) begin
                                    r_res   <= (r_op == OP_PUSH) ? r_opd : {24'd0, r_port};
                                    r_state <= S_WB;
                                end else if (!w_reg_ok) r_fault <= F_BADREG;
                                else if (r_op == OP_PUSHMEM && !w_addr_ok)
                                    r_fault <= F_BADADDR;
                                else begin
                                    r_res   <= (r_op == OP_PUSHMEM) ? r_mem_q : w_regv;
                                    r_state <= S_WB;
                                end
                            end
                            OP_POPREG, OP_POPMEM: begin
                                if (r_dcnt < DC'(1)) r_fault <= F_UNDER;
                                else if (!w_reg_ok) r_fault <= F_BADREG;
                                else if (r_op == OP_POPMEM && !w_addr_ok)
                                    r_fault <= F_BADADDR;
                                else r_state <= S_WB;
                            end
                            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                                if (r_dcnt < DC'(2)) r_fault <= F_UNDER;
                                else if (r_op == OP_DIV && r_a2 == 0) r_fault <= F_DIVZ;
                                else if (r_op == OP_ADD) begin
                                    r_res <= r_a1 + r_a2;  r_state <= S_WB;
                                end else if (r_op == OP_SUB) begin
                                    r_res <= r_a1 - r_a2;  r_state <= S_WB;
                                end else r_state <= S_ITER;
                            end
                            OP_SQRT: begin
                                if (r_dcnt < DC'(1)) r_fault <= F_UNDER;
                                else if (r_a2[31]) r_fault <= F_NSQRT;
                                else r_state <= S_ITER;
                            end
                            OP_JB, OP_JBE, OP_JA, OP_JAE, OP_JE, OP_JNE: begin
                                if (r_dcnt < DC'(2)) r_fault <= F_UNDER;
                                else begin
                                    r_dcnt <= r_dcnt - DC'(2);
                                    r_pc   <= w_cmp ? r_opd[15:0] : w_pc2;
                                    r_npc  <= w_cmp ? r_opd[15:0] : w_pc2;
                                end
                            end
                            OP_JMP: begin
                                r_pc  <= r_opd[15:0];
                                r_npc <= r_opd[15:0];
                            end
                            OP_CALL: begin
                                if (r_rcnt >= RC'(RETURN_DEPTH)) r_fault <= F_ROVER;
                                else begin
                                    r_rstk[r_rcnt[RW-1:0]] <= w_pc2;
                                    r_rcnt <= r_rcnt + RC'(1);
                                    r_pc   <= r_opd[15:0];
                                    r_npc  <= r_opd[15:0];
                                end
                            end
                            OP_RET: begin
                                if (r_rcnt < RC'(1)) r_fault <= F_RUNDER;
                                else begin
                                    r_rcnt <= r_rcnt - RC'(1);
                                    r_pc   <= r_rstk[RW'(r_rcnt - RC'(1))];
                                    r_npc  <= r_rstk[RW'(r_rcnt - RC'(1))];
                                end
                            end
                            OP_OUT: begin
                                if (r_dcnt < DC'(1)) r_fault <= F_UNDER;
                                else begin
                                    r_dcnt <= r_dcnt - DC'(1);
                                    r_ov   <= 1'b1;
                                    r_oval <= r_a2;
                                    r_pc   <= w_pc1;
                                    r_npc  <= w_pc1;
                                end
                            end
                            default: r_fault <= F_BADOP;
                        endcase
                    end
                end
                S_ITER: begin
                    if (w_iu_done) begin
                        r_res   <= w_iu_res;
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    r_state <= S_OUT;
                    case (r_op)
                        OP_PUSH, OP_PUSHREG, OP_PUSHMEM, OP_IN: begin
                            r_dstk[r_dcnt[DW-1:0]] <= r_res;
                            r_dcnt <= r_dcnt + DC'(1);
                            r_pc   <= (r_op == OP_IN) ? w_pc1 : w_pc2;
                            r_npc  <= (r_op == OP_IN) ? w_pc1 : w_pc2;
                        end
                        OP_POPREG, OP_POPMEM: begin
                            if (r_op == OP_POPREG) r_regs[r_opd[GW-1:0]] <= r_a2;
                            r_dcnt <= r_dcnt - DC'(1);
                            r_pc   <= w_pc2;
                            r_npc  <= w_pc2;
                        end
                        OP_SQRT: begin
                            r_dstk[DW'(r_dcnt - DC'(1))] <= r_res;
                            r_pc  <= w_pc1;
                            r_npc <= w_pc1;
                        end
                        default: begin
                            r_dstk[DW'(r_dcnt - DC'(2))] <= r_res;
                            r_dcnt <= r_dcnt - DC'(1);
                            r_pc   <= w_pc1;
                            r_npc  <= w_pc1;
                        end
                    endcase
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: sim/testbench.sv
// self-checking testbench of the stack machine executor with its own instruction predictor
module testbench;
    import sme_pkg::*;

    localparam int DATA_DEPTH   = 64;
    localparam int RETURN_DEPTH = 16;
    localparam int NUM_REGS     = 8;
    localparam int RAM_WORDS    = 8192;
    localparam int PC_START     = 3;
    localparam int RANDOM_ITEMS = 1130;
    localparam int PAUSE_AT     = 400;
    localparam int HOLD_AT      = 700;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_LEN    = 200;
    localparam int CYCLE_LIMIT  = 2000000;

    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] operand;
        logic [7:0]  port;
    } t_instr;

    typedef struct packed {
        logic [15:0] next_pc;
        logic        out_valid;
        logic [31:0] out_value;
        logic        halted;
        logic [3:0]  fault;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [4:0]  i_kind = '0;
    logic [31:0] i_operand = '0;
    logic [7:0]  i_port_value = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_next_pc;
    logic        o_out_valid;
    logic [31:0] o_out_value;
    logic        o_halted;
    logic [3:0]  o_fault;

    stack_machine_executor_core dut (.*);

    // machine copies: index 0 follows the block, index 1 plans the stimulus
    logic [31:0] dstk [2][DATA_DEPTH];
    logic [15:0] rstk [2][RETURN_DEPTH];
    logic [31:0] regs [2][NUM_REGS];
    logic [31:0] mem  [2][RAM_WORDS];
    int          dcnt [2];
    int          rcnt [2];
    logic [15:0] pcr  [2];
    logic        stopped [2];
    logic [3:0]  sticky [2];

    t_instr   pending_q[$];
    t_outcome expected_q[$];
    t_instr   on_bus;
    int       n_acc = 0;
    int       n_got = 0;
    int       errors = 0;
    int       hold_cnt = 0;
    bit       hold_done = 0;
    int       cycles = 0;

    function automatic logic [31:0] floor_sqrt(input logic [31:0] v);
        logic [31:0] res, bitv;
        res = 0;
        bitv = 32'h4000_0000;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] trunc_div(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ua, ub, q;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q = ua / ub;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    // executes one instruction on machine copy w, state is only updated when commit is set
    function automatic t_outcome execute(input int w, input t_instr it, input bit commit);
        logic [15:0] pc, np;
        logic [3:0]  f;
        logic        ov, wd, wr, wm, wrs, set_stop, holds;
        logic [31:0] oval, a1, a2, r, addr;
        int          n, newd, newr, wdi;
        pc = pcr[w];
        np = pc + 16'd2;
        n = dcnt[w];
        newd = n;
        newr = rcnt[w];
        f = F_NONE;
        {ov, wd, wr, wm, wrs, set_stop, holds} = '0;
        oval = 0; r = 0; addr = 0; wdi = 0; a1 = 0; a2 = 0;
        if (stopped[w] || sticky[w] != F_NONE)
            return '{pc, 1'b0, 32'd0, stopped[w], sticky[w]};
        case (it.kind)
            OP_HLT: begin
                set_stop = 1;
                np = pc;
            end
            OP_PUSH, OP_PUSHREG, OP_PUSHMEM, OP_IN: begin
                if (it.kind == OP_IN) np = pc + 16'd1;
                if (n >= DATA_DEPTH) f = F_OVER;
                else if (it.kind == OP_PUSH) r = it.operand;
                else if (it.kind == OP_IN) r = {24'd0, it.port};
                else if (it.operand >= NUM_REGS) f = F_BADREG;
                else begin
                    r = regs[w][it.operand];
                    if (it.kind == OP_PUSHMEM) begin
                        if (r >= RAM_WORDS) f = F_BADADDR;
                        else r = mem[w][r];
                    end
                end
                wd = 1; wdi = n; newd = n + 1;
            end
            OP_POPREG, OP_POPMEM: begin
                if (n < 1) f = F_UNDER;
                else if (it.operand >= NUM_REGS) f = F_BADREG;
                else begin
                    r = dstk[w][n-1];
                    if (it.kind == OP_POPREG) wr = 1;
                    else begin
                        addr = regs[w][it.operand];
                        if (addr >= RAM_WORDS) f = F_BADADDR;
                        else wm = 1;
                    end
                end
                newd = n - 1;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                np = pc + 16'd1;
                if (n < 2) f = F_UNDER;
                else begin
                    a2 = dstk[w][n-1];
                    a1 = dstk[w][n-2];
                    case (it.kind)
                        OP_ADD: r = a1 + a2;
                        OP_SUB: r = a1 - a2;
                        OP_MUL: r = a1 * a2;
                        default: begin
                            if (a2 == 0) f = F_DIVZ;
                            else r = trunc_div(a1, a2);
                        end
                    endcase
                end
                wd = 1; wdi = n - 2; newd = n - 1;
            end
            OP_SQRT: begin
                np = pc + 16'd1;
                if (n < 1) f = F_UNDER;
                else if (dstk[w][n-1][31]) f = F_NSQRT;
                else r = floor_sqrt(dstk[w][n-1]);
                wd = 1; wdi = n - 1;
            end
            OP_JB, OP_JBE, OP_JA, OP_JAE, OP_JE, OP_JNE: begin
                if (n < 2) f = F_UNDER;
                else begin
                    a2 = dstk[w][n-1];
                    a1 = dstk[w][n-2];
                    case (it.kind)
                        OP_JB:  holds = $signed(a1) < $signed(a2);
                        OP_JBE: holds = $signed(a1) <= $signed(a2);
                        OP_JA:  holds = $signed(a1) > $signed(a2);
                        OP_JAE: holds = $signed(a1) >= $signed(a2);
                        OP_JE:  holds = a1 == a2;
                        default: holds = a1 != a2;
                    endcase
                    if (holds) np = it.operand[15:0];
                end
                newd = n - 2;
            end
            OP_JMP: np = it.operand[15:0];
            OP_CALL: begin
                if (rcnt[w] >= RETURN_DEPTH) f = F_ROVER;
                else begin
                    wrs = 1;
                    newr = rcnt[w] + 1;
                    np = it.operand[15:0];
                end
            end
            OP_RET: begin
                if (rcnt[w] < 1) f = F_RUNDER;
                else begin
                    newr = rcnt[w] - 1;
                    np = rstk[w][newr];
                end
            end
            OP_OUT: begin
                np = pc + 16'd1;
                if (n < 1) f = F_UNDER;
                else begin
                    oval = dstk[w][n-1];
                    ov = 1;
                end
                newd = n - 1;
            end
            default: f = F_BADOP;
        endcase
        if (f != F_NONE) begin
            np = pc;
            ov = 0;
            oval = 0;
        end
        if (commit) begin
            if (f != F_NONE) begin
                sticky[w] = f;
            end else begin
                if (wd) dstk[w][wdi] = r;
                if (wr) regs[w][it.operand] = r;
                if (wm) mem[w][addr] = r;
                if (wrs) rstk[w][rcnt[w]] = pc + 16'd2;
                dcnt[w] = newd;
                rcnt[w] = newr;
                if (set_stop) stopped[w] = 1;
            end
            pcr[w] = np;
        end
        return '{np, ov, oval, set_stop, f};
    endfunction

    function automatic logic [31:0] rand_word();
        int sel;
        sel = $urandom_range(0, 7);
        case (sel)
            0, 1: return $urandom_range(0, RAM_WORDS - 1);
            2: begin
                case ($urandom_range(0, 4))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'hffff_ffff;
                    3: return 32'd0;
                    default: return 32'd1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic t_instr rand_instr();
        t_instr it;
        int     sel;
        sel = $urandom_range(0, 99);
        it.port = 8'($urandom_range(0, 255));
        it.operand = rand_word();
        if (sel < 22) it.kind = OP_PUSH;
        else if (sel < 28) it.kind = OP_PUSHREG;
        else if (sel < 32) it.kind = OP_PUSHMEM;
        else if (sel < 38) it.kind = OP_POPREG;
        else if (sel < 42) it.kind = OP_POPMEM;
        else if (sel < 46) it.kind = OP_ADD;
        else if (sel < 50) it.kind = OP_SUB;
        else if (sel < 54) it.kind = OP_MUL;
        else if (sel < 58) it.kind = OP_DIV;
        else if (sel < 61) it.kind = OP_SQRT;
        else if (sel < 73) it.kind = 5'(OP_JB + $urandom_range(0, 5));
        else if (sel < 76) it.kind = OP_JMP;
        else if (sel < 80) it.kind = OP_CALL;
        else if (sel < 84) it.kind = OP_RET;
        else if (sel < 90) it.kind = OP_IN;
        else it.kind = OP_OUT;
        if (it.kind inside {OP_PUSHREG, OP_PUSHMEM, OP_POPREG, OP_POPMEM})
            it.operand = $urandom_range(0, NUM_REGS - 1);
        return it;
    endfunction

    // queues an instruction only when it keeps the planned machine running
    function automatic void plan_clean(input t_instr it);
        t_outcome o;
        o = execute(1, it, 0);
        if (o.fault == F_NONE && !o.halted) begin
            void'(execute(1, it, 1));
            pending_q.push_back(it);
        end
    endfunction

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // stimulus plan and end of run
    initial begin
        t_instr   it;
        t_outcome o;
        int       tries;
        for (int w = 0; w < 2; w++) begin
            for (int a = 0; a < RAM_WORDS; a++) mem[w][a] = 0;
            for (int a = 0; a < NUM_REGS; a++) regs[w][a] = 0;
            for (int a = 0; a < DATA_DEPTH; a++) dstk[w][a] = 0;
            for (int a = 0; a < RETURN_DEPTH; a++) rstk[w][a] = 0;
            dcnt[w] = 0;
            rcnt[w] = 0;
            pcr[w] = 16'(PC_START);
            stopped[w] = 0;
            sticky[w] = F_NONE;
        end
        // directed: extremes, wrapping arithmetic, memory, stacks and ports
        plan_clean('{OP_PUSH, 32'h7fff_ffff, 8'h00});
        plan_clean('{OP_PUSH, 32'h8000_0000, 8'hff});
        plan_clean('{OP_SUB, 32'hffff_ffff, 8'h00});
        plan_clean('{OP_PUSH, 32'hffff_ffff, 8'h00});
        plan_clean('{OP_MUL, 32'd0, 8'h00});
        plan_clean('{OP_PUSH, 32'h8000_0000, 8'h00});
        plan_clean('{OP_PUSH, 32'hffff_ffff, 8'h00});
        plan_clean('{OP_DIV, 32'd0, 8'h00});
        plan_clean('{OP_PUSH, 32'hffff_fff9, 8'h00});
        plan_clean('{OP_PUSH, 32'd2, 8'h00});
        plan_clean('{OP_DIV, 32'd0, 8'h00});
        plan_clean('{OP_PUSH, 32'h7fff_ffff, 8'h00});
        plan_clean('{OP_SQRT, 32'd0, 8'h00});
        plan_clean('{OP_OUT, 32'd0, 8'h00});
        plan_clean('{OP_IN, 32'd0, 8'hff});
        plan_clean('{OP_PUSH, RAM_WORDS - 1, 8'h00});
        plan_clean('{OP_POPREG, 32'd7, 8'h00});
        plan_clean('{OP_POPMEM, 32'd7, 8'h00});
        plan_clean('{OP_PUSHMEM, 32'd7, 8'h00});
        plan_clean('{OP_PUSHREG, 32'd0, 8'h00});
        plan_clean('{OP_JNE, 32'h1234_ffff, 8'h00});
        plan_clean('{OP_CALL, 32'hffff_0000, 8'h00});
        plan_clean('{OP_RET, 32'd0, 8'h00});
        plan_clean('{OP_JMP, 32'h0000_8001, 8'h00});
        // random running programs
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            tries = 0;
            do begin
                it = rand_instr();
                o = execute(1, it, 0);
                tries++;
            end while ((o.fault != F_NONE || o.halted) && tries < 100);
            if (o.fault == F_NONE && !o.halted) plan_clean(it);
        end
        // one terminal stop or fault, then items that must be ignored
        do begin
            it = rand_instr();
            it.kind = 5'($urandom_range(0, 31));
            o = execute(1, it, 0);
        end while (o.fault == F_NONE && !o.halted);
        pending_q.push_back(it);
        for (int i = 0; i < 8; i++) pending_q.push_back(rand_instr());

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_q.size() == 0);
        @(posedge i_clk);
        wait (!i_valid && n_got == n_acc);
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("stack_machine_executor_core regression: pass");
        else
            $display("stack_machine_executor_core regression: fail");
        $finish;
    end

    // instruction driver
    always @(posedge i_clk) begin
        int acc, phase, idle_pct;
        acc = n_acc;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_q.push_back(execute(0, on_bus, 1));
                acc = n_acc + 1;
                n_acc <= acc;
            end
            phase = (acc / PHASE_LEN) % 4;
            idle_pct = (phase == 1) ? 64 : (phase == 3) ? 16 : 0;
            if (!i_valid || o_ready) begin
                if (pending_q.size() != 0 && !(acc == PAUSE_AT && n_got != acc)
                        && $urandom_range(0, 99) >= idle_pct) begin
                    on_bus = pending_q.pop_front();
                    i_kind <= on_bus.kind;
                    i_operand <= on_bus.operand;
                    i_port_value <= on_bus.port;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        t_outcome e;
        int       phase, stall_pct;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                n_got <= n_got + 1;
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result transfer pc %h", $time, o_next_pc);
                end else begin
                    e = expected_q.pop_front();
                    if (o_next_pc !== e.next_pc) begin
                        errors++;
                        $display("%0t next_pc expected %h actual %h", $time, e.next_pc,
                                 o_next_pc);
                    end
                    if (o_out_valid !== e.out_valid) begin
                        errors++;
                        $display("%0t out_valid expected %b actual %b", $time, e.out_valid,
                                 o_out_valid);
                    end
                    if (o_out_value !== e.out_value) begin
                        errors++;
                        $display("%0t out_value expected %h actual %h", $time, e.out_value,
                                 o_out_value);
                    end
                    if (o_halted !== e.halted) begin
                        errors++;
                        $display("%0t halted expected %b actual %b", $time, e.halted,
                                 o_halted);
                    end
                    if (o_fault !== e.fault) begin
                        errors++;
                        $display("%0t fault expected %0d actual %0d", $time, e.fault,
                                 o_fault);
                    end
                end
            end
            phase = (n_got / PHASE_LEN) % 4;
            stall_pct = (phase == 2) ? 64 : (phase == 3) ? 16 : 0;
            if (!hold_done && n_acc >= HOLD_AT) begin
                hold_done <= 1;
                hold_cnt <= HOLD_CYCLES;
                i_ready <= 1'b0;
            end else if (hold_cnt != 0) begin
                hold_cnt <= hold_cnt - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= $urandom_range(0, 99) >= stall_pct;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("stack_machine_executor_core regression: fail");
            $finish;
        end
    end

endmodule
